[sv/i2c_register_access_master_macros.svh]
// Assertion macros shared by the I2C register access master RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define I2CRAM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2cram assertion failed");

// The consequent holds in the cycle after the antecedent.
`define I2CRAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2cram assertion failed");

`endif

[sv/i2cram_pkg.sv]
// Shared types and constants for the I2C register access master.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package i2cram_pkg;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'b1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h68;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd2;

    // Request modes as they arrive on the input channel.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Request kinds after classification by the front end.
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Tick queue between the front end and the sequencer.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_IDX_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_tick;

endpackage

`default_nettype wire

[sv/i2cram_queue.sv]
// Front end of the I2C register access master: accepts ticks, classifies the
// request mode and holds them in a short queue. Depends on i2cram_pkg.
`default_nettype none
`include "i2c_register_access_master_macros.svh"

module i2cram_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire i2cram_pkg::t_in_item i_in_data,
    output logic                   o_q_valid,
    output i2cram_pkg::t_tick      o_q_tick,
    input  wire logic              i_pop
);
    import i2cram_pkg::*;

    t_tick               r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0]  r_wr_ptr;
    logic [Q_IDX_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                push;
    logic                pop;
    t_tick               tick;

    // Mode three and tick-only items both carry no request.
    always_comb begin
        tick.reg_addr   = i_in_data.reg_addr;
        tick.write_data = i_in_data.write_data;
        tick.sda_in     = i_in_data.sda_in;
        case (i_in_data.mode)
            MODE_WRITE: tick.kind = REQ_WRITE;
            MODE_READ:  tick.kind = REQ_READ;
            default:    tick.kind = REQ_NONE;
        endcase
    end

    assign o_in_stall = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_pop && o_q_valid;
    assign o_q_tick   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_IDX_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_IDX_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `I2CRAM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH))
    `I2CRAM_ASSERT_NEXT(a_count_up, push && !pop, r_count == $past(r_count) + Q_CNT_W'(1))
    `I2CRAM_ASSERT_NEXT(a_count_down, pop && !push, r_count == $past(r_count) - Q_CNT_W'(1))

endmodule

`default_nettype wire

[sv/i2cram_seq.sv]
// Back end of the I2C register access master: the bus sequencer, the
// configuration registers and the output register. Depends on i2cram_pkg.
`default_nettype none
`include "i2c_register_access_master_macros.svh"

module i2cram_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [i2cram_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [i2cram_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          i_q_valid,
    input  wire i2cram_pkg::t_tick             i_q_tick,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output i2cram_pkg::t_out_item              o_out_data
);
    import i2cram_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_S0   = 5'd1;
    localparam logic [4:0] ST_S1   = 5'd2;
    localparam logic [4:0] ST_S2   = 5'd3;
    localparam logic [4:0] ST_S3   = 5'd4;
    localparam logic [4:0] ST_WSET = 5'd5;
    localparam logic [4:0] ST_WHI  = 5'd6;
    localparam logic [4:0] ST_WLO  = 5'd7;
    localparam logic [4:0] ST_AREL = 5'd8;
    localparam logic [4:0] ST_AHI  = 5'd9;
    localparam logic [4:0] ST_ALO  = 5'd10;
    localparam logic [4:0] ST_RREL = 5'd11;
    localparam logic [4:0] ST_RHI  = 5'd12;
    localparam logic [4:0] ST_RLO  = 5'd13;
    localparam logic [4:0] ST_NSET = 5'd14;
    localparam logic [4:0] ST_NHI  = 5'd15;
    localparam logic [4:0] ST_NLO  = 5'd16;
    localparam logic [4:0] ST_P0   = 5'd17;
    localparam logic [4:0] ST_P1   = 5'd18;
    localparam logic [4:0] ST_P2   = 5'd19;
    localparam logic [4:0] ST_P3   = 5'd20;

    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_DATA   = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    logic [6:0]  r_dev_addr;
    logic [15:0] r_phase_ticks;

    logic [4:0]  r_step,      n_step;
    logic [1:0]  r_stage,     n_stage;
    logic [15:0] r_phase,     n_phase;
    logic [2:0]  r_bit,       n_bit;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_held_reg,  n_held_reg;
    logic [7:0]  r_held_data, n_held_data;
    logic        r_is_read,   n_is_read;
    logic        r_scl,       n_scl;
    logic        r_sda,       n_sda;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        do_enter;
    logic [4:0]  enter_step;
    logic        done;
    logic        err;
    logic [7:0]  rd;
    logic [15:0] limit;
    logic [16:0] phase_inc;

    // A tick is taken whenever the output register is free or being emptied.
    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign limit     = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;
    assign phase_inc = {1'b0, r_phase} + 17'd1;

    always_comb begin
        n_step      = r_step;
        n_stage     = r_stage;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_is_read   = r_is_read;
        n_scl       = r_scl;
        n_sda       = r_sda;
        do_enter    = 1'b0;
        enter_step  = ST_IDLE;
        done        = 1'b0;
        err         = 1'b0;
        rd          = 8'd0;

        if (r_step == ST_IDLE) begin
            if (i_q_tick.kind == REQ_WRITE || i_q_tick.kind == REQ_READ) begin
                n_held_reg  = i_q_tick.reg_addr;
                n_held_data = i_q_tick.write_data;
                n_is_read   = (i_q_tick.kind == REQ_READ);
                n_stage     = STG_ADDR_W;
                n_bit       = '0;
                n_shift     = '0;
                do_enter    = 1'b1;
                enter_step  = ST_S0;
            end
        end else if (phase_inc < {1'b0, limit}) begin
            n_phase = phase_inc[15:0];
        end else begin
            case (r_step)
                ST_S0: begin do_enter = 1'b1; enter_step = ST_S1; end
                ST_S1: begin do_enter = 1'b1; enter_step = ST_S2; end
                ST_S2: begin do_enter = 1'b1; enter_step = ST_S3; end
                ST_S3: begin
                    // The second address byte of a read carries the read bit.
                    n_shift    = {r_dev_addr, (r_stage == STG_ADDR_R)};
                    n_bit      = '0;
                    do_enter   = 1'b1;
                    enter_step = ST_WSET;
                end
                ST_WSET: begin do_enter = 1'b1; enter_step = ST_WHI; end
                ST_WHI:  begin do_enter = 1'b1; enter_step = ST_WLO; end
                ST_WLO: begin
                    do_enter = 1'b1;
                    if (r_bit == 3'd7) begin
                        enter_step = ST_AREL;
                    end else begin
                        n_bit      = r_bit + 3'd1;
                        n_shift    = {r_shift[6:0], 1'b0};
                        enter_step = ST_WSET;
                    end
                end
                ST_AREL: begin do_enter = 1'b1; enter_step = ST_AHI; end
                ST_AHI: begin
                    // The slave acknowledge is kept in the shift register.
                    n_shift    = {7'd0, i_q_tick.sda_in};
                    do_enter   = 1'b1;
                    enter_step = ST_ALO;
                end
                ST_ALO: begin
                    if (r_shift[0]) begin
                        // A NACK ends the transfer with no stop condition.
                        done    = 1'b1;
                        err     = 1'b1;
                        n_shift = '0;
                        n_step  = ST_IDLE;
                        n_phase = '0;
                    end else begin
                        do_enter = 1'b1;
                        case (r_stage)
                            STG_ADDR_W: begin
                                n_stage    = STG_REG;
                                n_shift    = r_held_reg;
                                n_bit      = '0;
                                enter_step = ST_WSET;
                            end
                            STG_REG: begin
                                if (r_is_read) begin
                                    n_stage    = STG_ADDR_R;
                                    enter_step = ST_S0;
                                end else begin
                                    n_stage    = STG_DATA;
                                    n_shift    = r_held_data;
                                    n_bit      = '0;
                                    enter_step = ST_WSET;
                                end
                            end
                            STG_DATA: enter_step = ST_P0;
                            default: begin
                                n_shift    = '0;
                                n_bit      = '0;
                                enter_step = ST_RREL;
                            end
                        endcase
                    end
                end
                ST_RREL: begin do_enter = 1'b1; enter_step = ST_RHI; end
                ST_RHI: begin
                    n_shift    = {r_shift[6:0], i_q_tick.sda_in};
                    do_enter   = 1'b1;
                    enter_step = ST_RLO;
                end
                ST_RLO: begin
                    do_enter = 1'b1;
                    if (r_bit == 3'd7) begin
                        enter_step = ST_NSET;
                    end else begin
                        n_bit      = r_bit + 3'd1;
                        enter_step = ST_RHI;
                    end
                end
                ST_NSET: begin do_enter = 1'b1; enter_step = ST_NHI; end
                ST_NHI:  begin do_enter = 1'b1; enter_step = ST_NLO; end
                ST_NLO:  begin do_enter = 1'b1; enter_step = ST_P0; end
                ST_P0:   begin do_enter = 1'b1; enter_step = ST_P1; end
                ST_P1:   begin do_enter = 1'b1; enter_step = ST_P2; end
                ST_P2:   begin do_enter = 1'b1; enter_step = ST_P3; end
                ST_P3: begin
                    done    = 1'b1;
                    rd      = r_is_read ? r_shift : 8'd0;
                    n_step  = ST_IDLE;
                    n_phase = '0;
                end
                default: begin
                    n_step  = ST_IDLE;
                    n_phase = '0;
                end
            endcase
        end

        // Entering a step restarts the phase count and sets the line levels.
        if (do_enter) begin
            n_step  = enter_step;
            n_phase = '0;
            case (enter_step)
                ST_S0: n_sda = 1'b1;
                ST_S1: begin n_scl = 1'b1; n_sda = 1'b1; end
                ST_S2: begin n_scl = 1'b1; n_sda = 1'b0; end
                ST_S3: begin n_scl = 1'b0; n_sda = 1'b0; end
                ST_WSET: begin n_scl = 1'b0; n_sda = n_shift[7]; end
                ST_AREL, ST_RREL, ST_NSET: begin n_scl = 1'b0; n_sda = 1'b1; end
                ST_WHI, ST_AHI, ST_RHI, ST_NHI: n_scl = 1'b1;
                ST_WLO, ST_ALO, ST_RLO, ST_NLO: n_scl = 1'b0;
                ST_P0: begin n_scl = 1'b0; n_sda = 1'b1; end
                ST_P1: begin n_scl = 1'b0; n_sda = 1'b0; end
                ST_P2: begin n_scl = 1'b1; n_sda = 1'b0; end
                ST_P3: begin n_scl = 1'b1; n_sda = 1'b1; end
                default: begin n_scl = r_scl; n_sda = r_sda; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEVICE_ADDRESS_RESET;
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev_addr    <= i_cfg_wdata[6:0];
                CFG_PHASE_TICKS:    r_phase_ticks <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_stage     <= STG_ADDR_W;
            r_phase     <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_held_reg  <= '0;
            r_held_data <= '0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_step      <= n_step;
                r_stage     <= n_stage;
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_held_reg  <= n_held_reg;
                r_held_data <= n_held_data;
                r_is_read   <= n_is_read;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_level   <= n_scl;
            r_out.sda_release <= n_sda;
            r_out.busy_res    <= (n_step != ST_IDLE);
            r_out.done_res    <= done;
            r_out.ack_error   <= err;
            r_out.read_data   <= rd;
        end
    end

    `I2CRAM_ASSERT_NOW(a_done_idle, r_out_valid && r_out.done_res, !r_out.busy_res)
    `I2CRAM_ASSERT_NOW(a_err_done, r_out_valid && r_out.ack_error, r_out.done_res)
    `I2CRAM_ASSERT_NOW(a_idle_phase, r_step == ST_IDLE, r_phase == '0)
    `I2CRAM_ASSERT_NEXT(a_tick_stays_idle,
        o_pop && r_step == ST_IDLE && i_q_tick.kind == REQ_NONE, r_step == ST_IDLE)

endmodule

`default_nettype wire

[sv/i2c_register_access_master.sv]
// With no stalls, a tick is written into the tick queue, then stepped by the sequencer,
// which registers its result in the output register for transfer out.
// Throughput: one tick per clock cycle while the output register is not stalled.
// Synchronous active-low reset empties the tick queue and output register,
// returns the sequencer to idle with SCL and SDA released high, and restores
// the device address (0x68) and phase length (two ticks).
`default_nettype none

// Top level: ties the tick queue to the bus sequencer.
// Depends on i2cram_pkg, i2cram_queue and i2cram_seq.
module i2c_register_access_master (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [i2cram_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [i2cram_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire i2cram_pkg::t_in_item               i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output i2cram_pkg::t_out_item                   o_out_data
);
    import i2cram_pkg::*;

    // Each input transfer is one timing tick of the bus sequencer. The front
    // end classifies the request mode (mode three counts as a plain tick) and
    // queues the tick; the sequencer takes one queued tick per cycle whenever
    // its output register is free or being read, so the four-entry queue buffers
    // between the two sides. Every tick yields exactly one output transfer.
    logic  q_valid;
    t_tick q_tick;
    logic  q_pop;

    i2cram_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_tick   (q_tick),
        .i_pop      (q_pop)
    );

    // The sequencer walks start, address, register, data or repeated start
    // and read phases, each lasting the configured number of ticks, and
    // reports done, NACK and the read byte on the tick the transaction ends.
    i2cram_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_tick    (q_tick),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the I2C register access master: random and directed
// ticks with a predictor of the bus sequencer built in. Depends on i2cram_pkg and
// the i2c_register_access_master RTL.
module tb;
    import i2cram_pkg::*;

    // The package names three request modes; the fourth encoding must act as a plain tick.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Steps of the bus sequencer as the predictor tracks them.
    typedef enum logic [4:0] {
        BS_IDLE, BS_START_REL, BS_START_IDLE, BS_START_COND, BS_START_HOLD,
        BS_BIT_SET, BS_BIT_HI, BS_BIT_LO, BS_ACK_REL, BS_ACK_HI, BS_ACK_LO,
        BS_RD_REL, BS_RD_HI, BS_RD_LO, BS_NAK_SET, BS_NAK_HI, BS_NAK_LO,
        BS_STOP_REL, BS_STOP_PULL, BS_STOP_CLK, BS_STOP_COND
    } t_bus_step;

    // Which byte of the transaction is on the wire.
    typedef enum logic [1:0] {BYTE_ADDR_W, BYTE_REG, BYTE_DATA, BYTE_ADDR_R} t_byte_stage;

    // How the emulated slave fills the bits of a read byte.
    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZEROS, FILL_ONES} t_read_fill;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;

    i2c_register_access_master dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ticks waiting to be driven, and the bus levels and status each one must produce.
    t_in_item  pending_ticks[$];
    t_out_item expected_bus[$];

    int unsigned ticks_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    bit          idling_on = 1'b1;

    // Behavior of the emulated slave while ticks are generated.
    int unsigned nack_pct = 0;
    bit          refuse_on = 1'b0;
    t_byte_stage refuse_stage = BYTE_ADDR_W;
    t_read_fill  read_fill = FILL_RANDOM;

    // Predictor copy of the configuration registers, at their reset values.
    logic [6:0]  cfg_dev_addr = DEVICE_ADDRESS_RESET;
    logic [15:0] cfg_phase_ticks = PHASE_TICKS_RESET;

    // Predictor copy of the sequencer state, at its reset values.
    t_bus_step   seq_step = BS_IDLE;
    t_byte_stage seq_stage = BYTE_ADDR_W;
    logic [15:0] seq_phase = '0;
    logic [3:0]  seq_bits = '0;
    logic [7:0]  seq_shift = '0;
    logic [7:0]  seq_reg = '0;
    logic [7:0]  seq_data = '0;
    logic        seq_is_read = 1'b0;
    logic        seq_scl = 1'b1;
    logic        seq_sda = 1'b1;
    logic        seq_done;
    logic        seq_err;
    logic [7:0]  seq_rd;

    // Moves the sequencer to a new step, restarting the phase count and setting
    // the line levels that the step drives.
    function automatic void enter_step(input t_bus_step s);
        seq_step  = s;
        seq_phase = '0;
        case (s)
            BS_START_REL: seq_sda = 1'b1;
            BS_START_IDLE: begin
                seq_scl = 1'b1;
                seq_sda = 1'b1;
            end
            BS_START_COND: begin
                seq_scl = 1'b1;
                seq_sda = 1'b0;
            end
            BS_START_HOLD: begin
                seq_scl = 1'b0;
                seq_sda = 1'b0;
            end
            BS_BIT_SET: begin
                seq_scl = 1'b0;
                seq_sda = seq_shift[7];
            end
            BS_ACK_REL, BS_RD_REL, BS_NAK_SET: begin
                seq_scl = 1'b0;
                seq_sda = 1'b1;
            end
            BS_BIT_HI, BS_ACK_HI, BS_RD_HI, BS_NAK_HI: seq_scl = 1'b1;
            BS_BIT_LO, BS_ACK_LO, BS_RD_LO, BS_NAK_LO: seq_scl = 1'b0;
            BS_STOP_REL: begin
                seq_scl = 1'b0;
                seq_sda = 1'b1;
            end
            BS_STOP_PULL: begin
                seq_scl = 1'b0;
                seq_sda = 1'b0;
            end
            BS_STOP_CLK: begin
                seq_scl = 1'b1;
                seq_sda = 1'b0;
            end
            BS_STOP_COND: begin
                seq_scl = 1'b1;
                seq_sda = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void load_byte(input logic [7:0] b);
        seq_shift = b;
        seq_bits  = '0;
        enter_step(BS_BIT_SET);
    endfunction

    // One phase has run out: take the next step of the transaction.
    function automatic void advance_step(input logic sda_in);
        case (seq_step)
            BS_START_REL:  enter_step(BS_START_IDLE);
            BS_START_IDLE: enter_step(BS_START_COND);
            BS_START_COND: enter_step(BS_START_HOLD);
            BS_START_HOLD: load_byte({cfg_dev_addr, seq_stage == BYTE_ADDR_R});
            BS_BIT_SET:    enter_step(BS_BIT_HI);
            BS_BIT_HI:     enter_step(BS_BIT_LO);
            BS_BIT_LO: begin
                if (seq_bits >= 4'd7) begin
                    enter_step(BS_ACK_REL);
                end else begin
                    seq_bits  = seq_bits + 4'd1;
                    seq_shift = seq_shift << 1;
                    enter_step(BS_BIT_SET);
                end
            end
            BS_ACK_REL: enter_step(BS_ACK_HI);
            BS_ACK_HI: begin
                // The acknowledge bit is parked in the shift register until SCL falls.
                seq_shift = {7'd0, sda_in};
                enter_step(BS_ACK_LO);
            end
            BS_ACK_LO: begin
                if (seq_shift[0]) begin
                    // A refused byte aborts at once: error flag, no STOP, lines left as they are.
                    seq_done  = 1'b1;
                    seq_err   = 1'b1;
                    seq_shift = '0;
                    seq_step  = BS_IDLE;
                    seq_phase = '0;
                end else begin
                    case (seq_stage)
                        BYTE_ADDR_W: begin
                            seq_stage = BYTE_REG;
                            load_byte(seq_reg);
                        end
                        BYTE_REG: begin
                            if (seq_is_read) begin
                                seq_stage = BYTE_ADDR_R;
                                enter_step(BS_START_REL);
                            end else begin
                                seq_stage = BYTE_DATA;
                                load_byte(seq_data);
                            end
                        end
                        BYTE_DATA: enter_step(BS_STOP_REL);
                        default: begin
                            seq_shift = '0;
                            seq_bits  = '0;
                            enter_step(BS_RD_REL);
                        end
                    endcase
                end
            end
            BS_RD_REL: enter_step(BS_RD_HI);
            BS_RD_HI: begin
                seq_shift = {seq_shift[6:0], sda_in};
                enter_step(BS_RD_LO);
            end
            BS_RD_LO: begin
                if (seq_bits >= 4'd7) begin
                    enter_step(BS_NAK_SET);
                end else begin
                    seq_bits = seq_bits + 4'd1;
                    enter_step(BS_RD_HI);
                end
            end
            BS_NAK_SET:   enter_step(BS_NAK_HI);
            BS_NAK_HI:    enter_step(BS_NAK_LO);
            BS_NAK_LO:    enter_step(BS_STOP_REL);
            BS_STOP_REL:  enter_step(BS_STOP_PULL);
            BS_STOP_PULL: enter_step(BS_STOP_CLK);
            BS_STOP_CLK:  enter_step(BS_STOP_COND);
            BS_STOP_COND: begin
                seq_done = 1'b1;
                if (seq_is_read) begin
                    seq_rd = seq_shift;
                end
                seq_step  = BS_IDLE;
                seq_phase = '0;
            end
            default: begin
                seq_step  = BS_IDLE;
                seq_phase = '0;
            end
        endcase
    endfunction

    // Advances the predictor by one tick and returns what the block must show for it.
    function automatic t_out_item predict_tick(input t_in_item it);
        t_out_item   r;
        int unsigned limit;
        seq_done = 1'b0;
        seq_err  = 1'b0;
        seq_rd   = '0;
        if (seq_step == BS_IDLE) begin
            // Only an idle sequencer takes a request; the START sequence begins on this same tick.
            if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
                seq_reg     = it.reg_addr;
                seq_data    = it.write_data;
                seq_is_read = (it.mode == MODE_READ);
                seq_stage   = BYTE_ADDR_W;
                seq_bits    = '0;
                seq_shift   = '0;
                enter_step(BS_START_REL);
            end
        end else begin
            // A phase length of zero behaves as one tick.
            limit = (cfg_phase_ticks == 16'd0) ? 1 : cfg_phase_ticks;
            if (seq_phase + 32'd1 < limit) begin
                seq_phase = seq_phase + 16'd1;
            end else begin
                advance_step(it.sda_in);
            end
        end
        r.scl_level   = seq_scl;
        r.sda_release = seq_sda;
        r.busy_res    = (seq_step != BS_IDLE);
        r.done_res    = seq_done;
        r.ack_error   = seq_err;
        r.read_data   = seq_rd;
        return r;
    endfunction

    // The emulated slave: it answers ACK slots and read bits from the predicted step,
    // and leaves SDA random everywhere else, where the block must ignore it.
    function automatic logic slave_sda();
        if (seq_step == BS_ACK_HI) begin
            return (refuse_on && seq_stage == refuse_stage) || ($urandom_range(0, 99) < nack_pct);
        end
        if (seq_step == BS_RD_HI && read_fill != FILL_RANDOM) begin
            return read_fill == FILL_ONES;
        end
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void queue_tick(input logic [1:0] mode, input logic [7:0] ra,
                                       input logic [7:0] wd);
        t_in_item it;
        it.mode       = mode;
        it.reg_addr   = ra;
        it.write_data = wd;
        it.sda_in     = slave_sda();
        pending_ticks.push_back(it);
        expected_bus.push_back(predict_tick(it));
        ticks_queued++;
    endfunction

    function automatic void idle_ticks(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            queue_tick($urandom_range(0, 1) ? MODE_TICK : MODE_UNUSED,
                       8'($urandom), 8'($urandom));
        end
    endfunction

    // Issues one request and keeps ticking until the transaction ends. With busy_noise
    // set, the ticks in between carry random modes, which the block must ignore.
    function automatic void run_request(input logic [1:0] mode, input logic [7:0] ra,
                                        input logic [7:0] wd, input bit busy_noise);
        queue_tick(mode, ra, wd);
        while (seq_step != BS_IDLE) begin
            queue_tick(busy_noise ? 2'($urandom_range(0, 3)) : MODE_TICK,
                       8'($urandom), 8'($urandom));
        end
    endfunction

    // Mostly well-behaved transactions with random content; a share of them meet a
    // slave that refuses bytes often.
    function automatic void random_traffic(input int unsigned target);
        int unsigned stop_at;
        stop_at = ticks_queued + target;
        while (ticks_queued < stop_at) begin
            idle_ticks($urandom_range(0, 3));
            nack_pct  = ($urandom_range(0, 99) < 15) ? 40 : 2;
            read_fill = t_read_fill'($urandom_range(0, 2));
            run_request($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                        8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Register writes go out only while the block is idle, so the predictor can
    // apply them at the same point of the tick stream.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS) begin
            cfg_dev_addr = value[6:0];
        end else begin
            cfg_phase_ticks = value;
        end
    endtask

    // Waits until every queued tick has been transferred and every result checked,
    // then lets the pipeline settle.
    task automatic drain();
        while (pending_ticks.size() != 0 || in_valid || expected_bus.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Input driver. A new tick is presented only when the previous transfer went
    // through or nothing was presented; a stalled tick holds its payload.
    int unsigned send_gap = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_ticks.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_ticks.pop_front();
                if (idling_on && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(1, 13);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and stall generator. A result counts when valid is high and
    // our stall is low at the edge; it is compared with the oldest expectation.
    int unsigned stall_left = 0;
    t_out_item   want;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_bus.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no expectation waiting", results_seen);
                    end
                end else begin
                    want = expected_bus.pop_front();
                    if (out_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result %0d: expected scl=%b sda=%b busy=%b done=%b ",
                                      "err=%b data=%02h, got scl=%b sda=%b busy=%b done=%b ",
                                      "err=%b data=%02h"}, results_seen,
                                     want.scl_level, want.sda_release, want.busy_res,
                                     want.done_res, want.ack_error, want.read_data,
                                     out_data.scl_level, out_data.sda_release,
                                     out_data.busy_res, out_data.done_res,
                                     out_data.ack_error, out_data.read_data);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 12);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Hard limit on the run, far above the slowest legal run.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset configuration (address 0x68, two ticks per phase).
        // The unused mode and a plain tick must both leave the bus alone; then the
        // address byte goes out with the reset address and the slave refuses it.
        queue_tick(MODE_UNUSED, 8'hFF, 8'hFF);
        queue_tick(MODE_TICK, 8'h00, 8'h00);
        nack_pct     = 0;
        refuse_on    = 1'b1;
        refuse_stage = BYTE_ADDR_W;
        run_request(MODE_WRITE, 8'h12, 8'h34, 1'b0);
        idle_ticks(3);

        // Directed part at one tick per phase: a clean write of all ones and a read
        // returning all ones, with ignored requests while busy.
        drain();
        write_reg(CFG_PHASE_TICKS, 16'd1);
        refuse_on = 1'b0;
        read_fill = FILL_ONES;
        run_request(MODE_WRITE, 8'h00, 8'hFF, 1'b1);
        run_request(MODE_READ, 8'hFF, 8'h00, 1'b1);
        // The slave refuses the register byte, the data byte and the address of the
        // read phase once each. After each abort the lines stay put until the next
        // START, which must release SDA first.
        refuse_on    = 1'b1;
        refuse_stage = BYTE_REG;
        run_request(MODE_READ, 8'hC3, 8'h3C, 1'b0);
        refuse_stage = BYTE_DATA;
        run_request(MODE_WRITE, 8'h81, 8'h7E, 1'b1);
        refuse_stage = BYTE_ADDR_R;
        run_request(MODE_READ, 8'h0F, 8'hF0, 1'b0);
        refuse_on = 1'b0;
        idle_ticks(3);

        // Random part. The upper bits of the address write are junk that the block
        // must drop, and a phase length of zero must act as one tick.
        drain();
        write_reg(CFG_DEVICE_ADDRESS, 16'hFFFF);
        write_reg(CFG_PHASE_TICKS, 16'd0);
        random_traffic(100);

        // Last stretch runs with no idling on either side.
        drain();
        idling_on = 1'b0;
        write_reg(CFG_DEVICE_ADDRESS, 16'($urandom));
        write_reg(CFG_PHASE_TICKS, 16'd1);
        random_traffic(100);

        // The longest phase: one request whose START phase must not end within the
        // ticks that follow. The block stays busy, so no register is written afterward.
        drain();
        write_reg(CFG_PHASE_TICKS, 16'hFFFF);
        queue_tick(MODE_READ, 8'($urandom), 8'($urandom));
        for (int i = 0; i < 40; i++) begin
            queue_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end
        drain();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/i2cram_pkg.sv
sv/i2cram_queue.sv
sv/i2cram_seq.sv
sv/i2c_register_access_master.sv
tb/tb.sv
